>>> rtl/core/apsbt_pkg.sv
package apsbt_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;
  localparam int TANH_DEPTH = 256;

  localparam int CNT_W    = $clog2(MAX_WIDTH);
  localparam int SIZE_W   = CNT_W + 1;
  localparam int SLOT_W   = $clog2(MAX_WIDTH / 2);
  localparam int LB_DEPTH = MAX_WIDTH / 2;
  localparam int PAIR_W   = DATA_WIDTH + 1;
  localparam int WIN_W    = DATA_WIDTH + 2;
  localparam int PROD_W   = WIN_W + DATA_WIDTH;
  localparam int SCALE_SH = FRAC_BITS + 2;
  localparam int VAL_W    = PROD_W - SCALE_SH + 1;
  localparam int OUT_W    = FRAC_BITS + 2;
  localparam int LUT_IDX_W = $clog2(TANH_DEPTH);
  localparam int LUT_SH   = FRAC_BITS + 3 - LUT_IDX_W;
  localparam int TANH_LIM = 4 << FRAC_BITS;
  localparam int TANH_ONE = 1 << FRAC_BITS;
  localparam int T_SH     = $clog2(2 * TANH_DEPTH);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [SIZE_W-1:0] MAP_SIZE_RST = SIZE_W'(28);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [SIZE_W-1:0] size_t;

  typedef struct packed {
    logic signed [PAIR_W-1:0]     pair;
    logic signed [DATA_WIDTH-1:0] coefficient;
    logic signed [DATA_WIDTH-1:0] bias_value;
    logic                         last;
  } s1_t;

  typedef logic [TANH_DEPTH-1:0][OUT_W-1:0] tanh_lut_t;

  // even size, clamped to 2..MAX_WIDTH
  function automatic size_t eff_size(input logic [CFG_DATA_W-1:0] v);
    size_t e;
    e = SIZE_W'({v[CFG_DATA_W-1:1], 1'b0});
    if (e < SIZE_W'(2)) e = SIZE_W'(2);
    if (e > SIZE_W'(MAX_WIDTH)) e = SIZE_W'(MAX_WIDTH);
    return e;
  endfunction

  // restoring division, used only while the table is built
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], a[k]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh at interval midpoints over [-4,4), Q30 series plus repeated squaring
  function automatic tanh_lut_t build_tanh_lut();
    tanh_lut_t   lut;
    logic [63:0] one;
    logic [63:0] mag;
    logic [63:0] t;
    logic [63:0] e;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] numr;
    logic [63:0] den;
    logic [63:0] val;
    int          num;
    one = 64'd1 << 30;
    for (int i = 0; i < TANH_DEPTH; i++) begin
      num  = 2 * i + 1 - TANH_DEPTH;
      mag  = (num < 0) ? 64'(-num) : 64'(num);
      t    = (mag << 30) >> T_SH;
      sum  = one;
      term = one;
      for (int n = 1; n <= 24; n++) begin
        term = udiv64((term * t) >> 30, 64'(n));
        if ((n & 1) == 1) sum = sum - term;
        else sum = sum + term;
      end
      e = sum;
      for (int s = 0; s < 4; s++) e = (e * e) >> 30;
      numr = (one - e) << (FRAC_BITS + 1);
      den  = one + e;
      val  = udiv64(numr + den, den << 1);
      lut[i] = (num < 0) ? OUT_W'(-val) : OUT_W'(val);
    end
    return lut;
  endfunction

  localparam tanh_lut_t TANH_LUT = build_tanh_lut();

endpackage

>>> rtl/core/apsbt_if.sv
interface apsbt_in_if import apsbt_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample;
  logic signed [DATA_WIDTH-1:0] coefficient;
  logic signed [DATA_WIDTH-1:0] bias_value;
  logic                         first_of_map;

  modport source (output valid, sample, coefficient, bias_value, first_of_map,
                  input ready);
  modport sink   (input valid, sample, coefficient, bias_value, first_of_map,
                  output ready);
endinterface

interface apsbt_out_if import apsbt_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] pooled;
  logic                    last_of_map;

  modport source (output valid, pooled, last_of_map, input ready);
  modport sink   (input valid, pooled, last_of_map, output ready);
endinterface

interface apsbt_cfg_if import apsbt_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/apsbt_front.sv
module apsbt_front import apsbt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  apsbt_in_if.sink          in_ch,
  input  size_t             w_eff,
  input  size_t             h_eff,
  output s1_t               s1_data,
  output logic signed [PAIR_W-1:0] lb_rdata,
  output logic              s1_valid,
  input  logic              s1_take
);

  logic [CNT_W-1:0] col_r, row_r, col_nxt, row_nxt, col_cur, row_cur;
  logic signed [DATA_WIDTH-1:0] partial_r;
  logic signed [PAIR_W-1:0]     pair;
  logic signed [PAIR_W-1:0]     line_mem [LB_DEPTH];
  logic signed [PAIR_W-1:0]     rdata_r;
  logic [SLOT_W-1:0]            slot;
  s1_t  s1_r, s1_nxt;
  logic s1_v_r, s1_v_nxt;
  logic accept, col_end, row_end, wr_en, rd_en;

  assign in_ch.ready = !s1_v_r || s1_take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    col_cur = in_ch.first_of_map ? '0 : col_r;
    row_cur = in_ch.first_of_map ? '0 : row_r;
    slot    = col_cur[SLOT_W:1];
    pair    = PAIR_W'(partial_r) + PAIR_W'(in_ch.sample);
    col_end = (SIZE_W'(col_cur) + SIZE_W'(1)) >= w_eff;
    row_end = (SIZE_W'(row_cur) + SIZE_W'(1)) >= h_eff;
    wr_en   = accept && col_cur[0] && !row_cur[0];
    rd_en   = accept && col_cur[0] && row_cur[0];

    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_cur + CNT_W'(1);
      end else begin
        col_nxt = col_cur + CNT_W'(1);
        row_nxt = row_cur;
      end
    end

    s1_nxt.pair        = pair;
    s1_nxt.coefficient = in_ch.coefficient;
    s1_nxt.bias_value  = in_ch.bias_value;
    s1_nxt.last        = col_end && row_end;

    s1_v_nxt = s1_v_r;
    if (rd_en) begin
      s1_v_nxt = 1'b1;
    end else if (s1_take) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  // line buffer of even-row pair sums; a write always leads its read by one map row of transfers
  always_ff @(posedge clk) begin
    if (accept && !col_cur[0]) begin
      partial_r <= in_ch.sample;
    end
    if (wr_en) begin
      line_mem[slot] <= pair;
    end
    if (rd_en) begin
      rdata_r <= line_mem[slot];
      s1_r    <= s1_nxt;
    end
  end

  assign s1_data  = s1_r;
  assign lb_rdata = rdata_r;
  assign s1_valid = s1_v_r;

  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("line buffer read and write in one cycle");

  a_s1_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_take |-> !in_ch.ready)
    else $error("stage 1 would be overwritten");

  a_first_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.first_of_map |=> col_r == CNT_W'(1) && row_r == '0)
    else $error("map start did not restart position");

endmodule

>>> rtl/core/apsbt_post.sv
module apsbt_post import apsbt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  s1_t                      s1_data,
  input  logic signed [PAIR_W-1:0] lb_rdata,
  input  logic                     s1_valid,
  output logic                     s1_take,
  apsbt_out_if.source              out_ch
);

  localparam logic signed [VAL_W-1:0] LIM_V = VAL_W'(TANH_LIM);
  localparam logic signed [OUT_W-1:0] ONE_V = OUT_W'(TANH_ONE);

  logic v2_r, v3_r, v4_r, v5_r;
  logic en2, en3, en4, en5;

  logic signed [WIN_W-1:0]      win_r;
  logic signed [DATA_WIDTH-1:0] coef2_r, bias2_r, bias3_r;
  logic                         last2_r, last3_r, last4_r, last5_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [VAL_W-1:0]      val, off_val;
  logic                         sat_lo_r, sat_hi_r;
  logic [LUT_IDX_W-1:0]         idx_r;
  logic signed [OUT_W-1:0]      pooled_r, pooled_nxt;

  assign en5     = !v5_r || out_ch.ready;
  assign en4     = !v4_r || en5;
  assign en3     = !v3_r || en4;
  assign en2     = !v2_r || en3;
  assign s1_take = en2;

  always_comb begin
    val     = VAL_W'(prod_r >>> SCALE_SH) + VAL_W'(bias3_r);
    off_val = val + LIM_V;
    if (sat_lo_r) begin
      pooled_nxt = -ONE_V;
    end else if (sat_hi_r) begin
      pooled_nxt = ONE_V;
    end else begin
      pooled_nxt = $signed(TANH_LUT[idx_r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en2) v2_r <= s1_valid;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid) begin
      win_r   <= WIN_W'(lb_rdata) + WIN_W'(s1_data.pair);
      coef2_r <= s1_data.coefficient;
      bias2_r <= s1_data.bias_value;
      last2_r <= s1_data.last;
    end
    if (en3 && v2_r) begin
      prod_r  <= PROD_W'(win_r) * PROD_W'(coef2_r);
      bias3_r <= bias2_r;
      last3_r <= last2_r;
    end
    if (en4 && v3_r) begin
      sat_lo_r <= val < -LIM_V;
      sat_hi_r <= val >= LIM_V;
      idx_r    <= off_val[LUT_SH +: LUT_IDX_W];
      last4_r  <= last3_r;
    end
    if (en5 && v4_r) begin
      pooled_r <= pooled_nxt;
      last5_r  <= last4_r;
    end
  end

  assign out_ch.valid       = v5_r;
  assign out_ch.pooled      = pooled_r;
  assign out_ch.last_of_map = last5_r;

  a_pooled_range: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> pooled_r >= -ONE_V && pooled_r <= ONE_V)
    else $error("pooled value out of range");

  a_sat_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> !(sat_lo_r && sat_hi_r))
    else $error("both saturation flags set");

  a_stage4_drains: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && en5 |=> v5_r)
    else $error("result lost between tanh stage and output");

endmodule

>>> rtl/core/avg_pool_scale_bias_tanh_unit.sv
// 2x2 average pooling with trainable scale, bias and tanh for one feature map in raster
// order. Takes one sample per cycle with no gaps while the result side keeps up; each result
// is registered in stage 1 and then in stages 2 to 5 after the transfer of the odd sample of
// an odd row. Results the output does not take collect in five stages; once all five hold
// one, the input is held off. Even-row pair sums sit in a 32-entry line buffer with a
// registered read, read or written at most once per transfer; no clearing pass follows
// reset. The last result of a map carries last_of_map. A size write takes effect from the
// next sample transfer; write sizes only between maps, with no result pending.
module avg_pool_scale_bias_tanh_unit import apsbt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  apsbt_in_if.sink    in_ch,
  apsbt_out_if.source out_ch,
  apsbt_cfg_if.sink   cfg_ch
);

  size_t w_eff_r, h_eff_r;
  s1_t   s1_data;
  logic signed [PAIR_W-1:0] lb_rdata;
  logic  s1_valid, s1_take;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= MAP_SIZE_RST;
      h_eff_r <= MAP_SIZE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_MAP_WIDTH:  w_eff_r <= eff_size(cfg_ch.data);
        REG_MAP_HEIGHT: h_eff_r <= eff_size(cfg_ch.data);
        default: ;
      endcase
    end
  end

  apsbt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .w_eff    (w_eff_r),
    .h_eff    (h_eff_r),
    .s1_data  (s1_data),
    .lb_rdata (lb_rdata),
    .s1_valid (s1_valid),
    .s1_take  (s1_take)
  );

  apsbt_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_data  (s1_data),
    .lb_rdata (lb_rdata),
    .s1_valid (s1_valid),
    .s1_take  (s1_take),
    .out_ch   (out_ch)
  );

endmodule
